// ===== hdl/eth_rxc_pkg.sv =====
// Shared types and constants for the receive classifier and ARP responder.
`timescale 1ns / 1ps
package eth_rxc_pkg;

	localparam int PORT_SLOTS = 4;

	// frame layout (byte offsets from destination MAC)
	localparam int TYPE_POS     = 12;
	localparam int ARP_OP_POS   = 20;
	localparam int IP_HDR_POS   = 'h14;
	localparam int IP_PROTO_POS = IP_HDR_POS + 3;
	localparam int SHA_POS      = 22;
	localparam int SPA_POS      = 28;
	localparam int UDP_PORT_POS = 'h24;
	localparam int TPA_POS      = 38;
	localparam int REPLY_LEN    = 'h2A;

	localparam int IDX_W       = 6;
	localparam int REPLY_IDX_W = $clog2(REPLY_LEN);

	localparam logic [15:0] ETYPE_ARP  = 16'h0806;
	localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
	localparam logic [15:0] ARP_OP_REQ = 16'h0001;
	localparam logic [7:0]  IP_PROTO_UDP = 8'd17;

	// configuration port
	localparam int CFG_REGS   = 2 + PORT_SLOTS;
	localparam int CFG_IDX_W  = $clog2(CFG_REGS);
	localparam int CFG_DATA_W = 48;
	localparam int CFG_OUR_IP     = 0;
	localparam int CFG_OUR_MAC    = 1;
	localparam int CFG_PORT_SLOT0 = 2;

	localparam logic [31:0] OUR_IP_RESET = 32'hC0A8_010A;

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [2:0] {
		VERDICT_UDP_DELIVERED = 3'd0,
		VERDICT_ARP_REPLIED   = 3'd1,
		VERDICT_ARP_IGNORED   = 3'd2,
		VERDICT_UNKNOWN_TYPE  = 3'd3,
		VERDICT_NOT_UDP       = 3'd4,
		VERDICT_NO_PORT       = 3'd5,
		VERDICT_SHORT         = 3'd6
	} verdict_t;

	typedef logic [PORT_SLOTS-1:0][15:0] port_slots_t;

	// one classified frame, handed from front to back
	typedef struct packed {
		logic        reply;
		verdict_t    verdict;
		logic [1:0]  slot;
		logic [47:0] sender_hw;
		logic [31:0] sender_pa;
		logic [31:0] target_pa;
	} job_t;

endpackage

// ===== hdl/eth_rxc_if.sv =====
// Valid/ready channel interfaces for received bytes and result items.
`timescale 1ns / 1ps
interface eth_rxc_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       frame_end;

	modport source (output valid, rx_byte, frame_end, input ready);
	modport sink   (input valid, rx_byte, frame_end, output ready);
endinterface

interface eth_rxc_tx_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] tx_byte;
	logic       tx_last;
	logic [2:0] verdict;
	logic [1:0] port_slot;
	logic       result_last;

	modport source (output valid, kind, tx_byte, tx_last, verdict, port_slot, result_last,
		input ready);
	modport sink   (input valid, kind, tx_byte, tx_last, verdict, port_slot, result_last,
		output ready);
endinterface

// ===== hdl/eth_rxc_front.sv =====
// Front end: byte capture of header fields and frame classification.
`timescale 1ns / 1ps
module eth_rxc_front
	import eth_rxc_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	eth_rxc_rx_if.sink     rx,
	input  logic           q_full,
	input  logic [31:0]    our_ip,
	input  port_slots_t    port_slot,
	output logic           job_valid,
	output job_t           job
);

	logic [IDX_W-1:0] idx_q;
	logic [15:0] ether_type_q, arp_op_q, dest_port_q;
	logic [7:0]  ip_proto_q;
	logic [47:0] sha_q;
	logic [31:0] spa_q, tpa_q;

	logic [15:0] ether_type_n, arp_op_n, dest_port_n;
	logic [7:0]  ip_proto_n;
	logic [47:0] sha_n;
	logic [31:0] spa_n, tpa_n;

	logic       accept;
	logic       hit;
	logic [1:0] hit_slot;
	logic [7:0] b;
	int         i;

	assign rx.ready = !q_full;
	assign accept   = rx.valid && rx.ready;
	assign b        = rx.rx_byte;
	assign i        = int'(idx_q);

	always_comb begin
		ether_type_n = ether_type_q;
		arp_op_n     = arp_op_q;
		dest_port_n  = dest_port_q;
		ip_proto_n   = ip_proto_q;
		sha_n        = sha_q;
		spa_n        = spa_q;
		tpa_n        = tpa_q;
		if (i >= TYPE_POS && i < TYPE_POS + 2) ether_type_n = {ether_type_q[7:0], b};
		if (i == IP_PROTO_POS) ip_proto_n = b;
		if (i >= UDP_PORT_POS && i < UDP_PORT_POS + 2) dest_port_n = {dest_port_q[7:0], b};
		if (i >= ARP_OP_POS && i < ARP_OP_POS + 2) arp_op_n = {arp_op_q[7:0], b};
		if (i >= SHA_POS && i < SHA_POS + 6) sha_n = {sha_q[39:0], b};
		if (i >= SPA_POS && i < SPA_POS + 4) spa_n = {spa_q[23:0], b};
		if (i >= TPA_POS && i < REPLY_LEN) tpa_n = {tpa_q[23:0], b};
	end

	// lowest nonzero matching slot wins
	always_comb begin
		hit      = 1'b0;
		hit_slot = '0;
		for (int s = PORT_SLOTS - 1; s >= 0; s--) begin
			if (port_slot[s] != '0 && port_slot[s] == dest_port_n) begin
				hit      = 1'b1;
				hit_slot = 2'(s);
			end
		end
	end

	// i is the index of the final byte (held at 63 once reached), so frame length is at least i + 1
	always_comb begin
		job.reply     = 1'b0;
		job.slot      = '0;
		job.sender_hw = sha_n;
		job.sender_pa = spa_n;
		job.target_pa = tpa_n;
		if (i < TYPE_POS + 1) begin
			job.verdict = VERDICT_SHORT;
		end else if (ether_type_n == ETYPE_ARP) begin
			if (i < REPLY_LEN - 1) begin
				job.verdict = VERDICT_SHORT;
			end else if (arp_op_n == ARP_OP_REQ && tpa_n == our_ip) begin
				job.verdict = VERDICT_ARP_REPLIED;
				job.reply   = 1'b1;
			end else begin
				job.verdict = VERDICT_ARP_IGNORED;
			end
		end else if (ether_type_n == ETYPE_IPV4) begin
			if (i < IP_PROTO_POS) begin
				job.verdict = VERDICT_SHORT;
			end else if (ip_proto_n != IP_PROTO_UDP) begin
				job.verdict = VERDICT_NOT_UDP;
			end else if (i < UDP_PORT_POS + 1) begin
				job.verdict = VERDICT_SHORT;
			end else if (hit) begin
				job.verdict = VERDICT_UDP_DELIVERED;
				job.slot    = hit_slot;
			end else begin
				job.verdict = VERDICT_NO_PORT;
			end
		end else begin
			job.verdict = VERDICT_UNKNOWN_TYPE;
		end
	end

	assign job_valid = accept && rx.frame_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (accept) begin
			if (rx.frame_end) idx_q <= '0;
			else if (idx_q != '1) idx_q <= idx_q + 1'b1;
		end
	end

	// fields are fully rewritten before any verdict that reads them
	always_ff @(posedge clk) begin
		if (accept) begin
			ether_type_q <= ether_type_n;
			arp_op_q     <= arp_op_n;
			dest_port_q  <= dest_port_n;
			ip_proto_q   <= ip_proto_n;
			sha_q        <= sha_n;
			spa_q        <= spa_n;
			tpa_q        <= tpa_n;
		end
	end

endmodule

// ===== hdl/eth_rxc_queue.sv =====
// Short job queue between classifier front end and reply back end.
`timescale 1ns / 1ps
module eth_rxc_queue
	import eth_rxc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output logic full,
	output logic empty,
	output job_t head
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = count_q == CNT_W'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_job;
	end

endmodule

// ===== hdl/eth_rxc_back.sv =====
// Back end: streams ARP reply bytes and the verdict for each queued job.
`timescale 1ns / 1ps
module eth_rxc_back
	import eth_rxc_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic [47:0]    our_mac,
	input  logic           q_empty,
	input  job_t           head,
	output logic           pop,
	eth_rxc_tx_if.source   tx
);

	logic [0:REPLY_LEN-1][7:0] reply_bytes;
	logic [REPLY_IDX_W-1:0]    k_q;
	logic                      out_valid_q;
	logic                      kind_q, tx_last_q, result_last_q;
	logic [7:0]                tx_byte_q;
	logic [2:0]                verdict_q;
	logic [1:0]                slot_q;
	logic                      advance, in_reply, reply_end;

	assign reply_bytes = {
		head.sender_hw, our_mac,
		8'h08, 8'h06, 8'h00, 8'h01, 8'h08, 8'h00, 8'd6, 8'd4, 8'h00, 8'h02,
		our_mac, head.target_pa, head.sender_hw, head.sender_pa
	};

	assign advance   = (!out_valid_q || tx.ready) && !q_empty;
	assign in_reply  = head.reply && (k_q < REPLY_IDX_W'(REPLY_LEN));
	assign reply_end = k_q == REPLY_IDX_W'(REPLY_LEN - 1);
	assign pop       = advance && !in_reply;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			k_q         <= '0;
		end else begin
			if (advance) out_valid_q <= 1'b1;
			else if (tx.ready) out_valid_q <= 1'b0;
			if (advance) begin
				if (in_reply) k_q <= k_q + 1'b1;
				else k_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (in_reply) begin
				kind_q        <= 1'b1;
				tx_byte_q     <= reply_bytes[k_q];
				tx_last_q     <= reply_end;
				verdict_q     <= '0;
				slot_q        <= '0;
				result_last_q <= 1'b0;
			end else begin
				kind_q        <= 1'b0;
				tx_byte_q     <= '0;
				tx_last_q     <= 1'b0;
				verdict_q     <= head.verdict;
				slot_q        <= head.slot;
				result_last_q <= 1'b1;
			end
		end
	end

	assign tx.valid       = out_valid_q;
	assign tx.kind        = kind_q;
	assign tx.tx_byte     = tx_byte_q;
	assign tx.tx_last     = tx_last_q;
	assign tx.verdict     = verdict_q;
	assign tx.port_slot   = slot_q;
	assign tx.result_last = result_last_q;

endmodule

// ===== hdl/eth_rx_classifier_arp_responder.sv =====
// Top level: receive classifier with ARP responder and UDP port filter.
//
//  channel  dir  handshake      payload
//  rx       in   valid/ready    rx_byte[7:0], frame_end
//  tx       out  valid/ready    kind, tx_byte[7:0], tx_last, verdict[2:0], port_slot[1:0],
//                               result_last
//  cfg      in   cfg_we         cfg_index[2:0], cfg_data[47:0]
//
// One rx byte per cycle while rx.ready is high; the frame is classified in the cycle of
// its final byte. Each frame yields one tx transaction, or 43 for an answered ARP request,
// one per cycle while tx.ready is high; the tx output register sets that rate. A two-entry
// job queue lets rx keep running while replies drain; rx.ready drops only when that queue
// is full. Reset restores the register defaults and empties the queue and output stage.
`timescale 1ns / 1ps
module eth_rx_classifier_arp_responder
	import eth_rxc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	eth_rxc_rx_if.sink            rx,
	eth_rxc_tx_if.source          tx,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [31:0] our_ip_q;
	logic [47:0] our_mac_q;
	port_slots_t port_slot_q;

	logic job_valid, q_full, q_empty, pop;
	job_t job, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			our_ip_q    <= OUR_IP_RESET;
			our_mac_q   <= '0;
			port_slot_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_IDX_W'(CFG_OUR_IP)) our_ip_q <= cfg_data[31:0];
			if (cfg_index == CFG_IDX_W'(CFG_OUR_MAC)) our_mac_q <= cfg_data[47:0];
			for (int s = 0; s < PORT_SLOTS; s++) begin
				if (cfg_index == CFG_IDX_W'(CFG_PORT_SLOT0 + s)) port_slot_q[s] <= cfg_data[15:0];
			end
		end
	end

	eth_rxc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.q_full    (q_full),
		.our_ip    (our_ip_q),
		.port_slot (port_slot_q),
		.job_valid (job_valid),
		.job       (job)
	);

	eth_rxc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_valid),
		.push_job (job),
		.pop      (pop),
		.full     (q_full),
		.empty    (q_empty),
		.head     (head)
	);

	eth_rxc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.our_mac (our_mac_q),
		.q_empty (q_empty),
		.head    (head),
		.pop     (pop),
		.tx      (tx)
	);

endmodule
